/* src/srpilux_pkg.sv */
// Shared types, constants and the voltage table lookup for the split-range light controller.
package srpilux_pkg;

    localparam int TABLE_ENTRIES_DEF = 11;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int POS_W  = 27;

    localparam logic [2:0] REG_AUTO_MODE    = 3'd0;
    localparam logic [2:0] REG_TARGET_LEVEL = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd3;
    localparam logic [2:0] REG_DWELL_MS     = 3'd4;
    localparam logic [2:0] REG_VOLT_LO      = 3'd5;
    localparam logic [2:0] REG_VOLT_HI      = 3'd6;

    localparam logic [15:0] TARGET_RESET = 16'd500;
    localparam logic [15:0] PROP_RESET   = 16'd3277;
    localparam logic [15:0] INTEG_RESET  = 16'd328;
    localparam logic [31:0] DWELL_RESET  = 32'd10000;

    localparam logic [23:0] PCT_MAX      = 24'd13107200;
    localparam logic [23:0] PCT_HUNDRED  = 24'd6553600;
    localparam logic [23:0] PCT_HANDOVER = 24'd6225920;
    localparam logic [22:0] PCT_LOW_LED  = 23'd1638400;
    localparam logic [22:0] PCT_TEN      = 23'd655360;
    localparam logic [9:0]  VOLT_FULL    = 10'd1000;
    localparam logic [26:0] RECIP_TEN    = 27'd53687092;
    localparam logic [26:0] RECIP_HUNDRED = 27'd167773;

    localparam logic signed [16:0] ERR_WIDE  = 17'sd150;
    localparam logic signed [16:0] ERR_SMALL = 17'sd5;

    typedef struct packed {
        logic [15:0] lux_sample;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [9:0] foil_voltage;
        logic [9:0] led_compare;
        logic       lockout;
    } result_t;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_ERR  = 15'b000000000000010,
        ST_MI   = 15'b000000000000100,
        ST_IACC = 15'b000000000001000,
        ST_EFF  = 15'b000000000010000,
        ST_BR   = 15'b000000000100000,
        ST_LED  = 15'b000000001000000,
        ST_POS  = 15'b000000010000000,
        ST_DIV  = 15'b000000100000000,
        ST_MA   = 15'b000001000000000,
        ST_MB   = 15'b000010000000000,
        ST_SUM  = 15'b000100000000000,
        ST_Q    = 15'b001000000000000,
        ST_VOLT = 15'b010000000000000,
        ST_DONE = 15'b100000000000000
    } state_t;

    function automatic logic [9:0] table_entry(input logic [59:0] lo, input logic [49:0] hi,
                                               input logic [3:0] k);
        logic [9:0] v;
        case (k)
            4'd0:    v = lo[9:0];
            4'd1:    v = lo[19:10];
            4'd2:    v = lo[29:20];
            4'd3:    v = lo[39:30];
            4'd4:    v = lo[49:40];
            4'd5:    v = lo[59:50];
            4'd6:    v = hi[9:0];
            4'd7:    v = hi[19:10];
            4'd8:    v = hi[29:20];
            4'd9:    v = hi[39:30];
            4'd10:   v = hi[49:40];
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/split_range_pi_lux_controller.sv */
// Top level of the split-range PI light controller with its sequencer and shared multiplier.
// Manual mode goes from ERR straight to DONE. Effort above 100 percent takes the LED step after BR.
// Interpolation: the subtract loop over segments finds the segment, then MA, MB, SUM, Q and VOLT run.
// Every product goes through the one registered multiplier; one item is in work at a time.
// Reset clears the controller state and loads the register defaults; no result is pending.
module split_range_pi_lux_controller
    import srpilux_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_ready,
    input  sample_t           smp_data,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int SEGS  = TABLE_ENTRIES - 1;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [POS_W-1:0] SPAN = POS_W'(PCT_HUNDRED);

    logic        auto_mode_reg;
    logic [15:0] target_level_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [31:0] dwell_ms_reg;
    logic [59:0] volt_lo_reg;
    logic [49:0] volt_hi_reg;

    state_t      state_reg, state_next;
    sample_t     smp_reg;
    logic [23:0] integ_acc_reg;
    logic [22:0] led_level_reg;
    logic        led_was_lit_reg;
    logic [31:0] switch_time_reg;
    logic [9:0]  held_voltage_reg;
    logic        lock_reg;
    logic signed [16:0] err_reg;
    logic [23:0] effort_reg;
    logic [POS_W-1:0] rem_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [33:0] acc_reg;
    logic [16:0] v_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic        wr_en;
    logic        lit;
    logic [31:0] sw_new;
    logic        lock_new;
    logic signed [16:0] err_raw, err_dz;
    logic        zone;
    logic signed [35:0] isum;
    logic [23:0] eff_diff;
    logic [26:0] eff_x9;
    logic [24:0] led_sum;
    logic [34:0] vsum;
    logic [9:0]  entry_a, entry_b, entry_s;
    logic [26:0] led_x10;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign smp_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        case (paddr[5:3])
            REG_AUTO_MODE:    prdata = DATA_W'(auto_mode_reg);
            REG_TARGET_LEVEL: prdata = DATA_W'(target_level_reg);
            REG_PROP_GAIN:    prdata = DATA_W'(prop_gain_reg);
            REG_INTEG_GAIN:   prdata = DATA_W'(integ_gain_reg);
            REG_DWELL_MS:     prdata = DATA_W'(dwell_ms_reg);
            REG_VOLT_LO:      prdata = DATA_W'(volt_lo_reg);
            REG_VOLT_HI:      prdata = DATA_W'(volt_hi_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg    <= 1'b1;
            target_level_reg <= TARGET_RESET;
            prop_gain_reg    <= PROP_RESET;
            integ_gain_reg   <= INTEG_RESET;
            dwell_ms_reg     <= DWELL_RESET;
            volt_lo_reg      <= '0;
            volt_hi_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                REG_AUTO_MODE:    auto_mode_reg    <= pwdata[0];
                REG_TARGET_LEVEL: target_level_reg <= pwdata[15:0];
                REG_PROP_GAIN:    prop_gain_reg    <= pwdata[15:0];
                REG_INTEG_GAIN:   integ_gain_reg   <= pwdata[15:0];
                REG_DWELL_MS:     dwell_ms_reg     <= pwdata[31:0];
                REG_VOLT_LO:      volt_lo_reg      <= pwdata[59:0];
                REG_VOLT_HI:      volt_hi_reg      <= pwdata[49:0];
                default:          ;
            endcase
        end
    end

    // Lockout test against the switch time as it stands after this sample's update.
    assign lit      = (led_level_reg != '0);
    assign sw_new   = (auto_mode_reg && (lit != led_was_lit_reg)) ? smp_reg.now_ms
                                                                  : switch_time_reg;
    assign lock_new = ((smp_reg.now_ms - sw_new) < dwell_ms_reg);

    assign err_raw = $signed({1'b0, target_level_reg}) - $signed({1'b0, smp_reg.lux_sample});
    assign zone    = (integ_acc_reg >= PCT_HANDOVER) || lit;

    always_comb
    begin
        err_dz = err_raw;
        if (zone)
        begin
            if (!lit)
            begin
                if ((err_raw > 0) && ((err_raw <= ERR_WIDE) || lock_new))
                begin
                    err_dz = '0;
                end
            end
            else if (led_level_reg <= PCT_LOW_LED)
            begin
                if ((err_raw < 0) && ((err_raw >= -ERR_WIDE) || lock_new))
                begin
                    err_dz = '0;
                end
            end
        end
        else if ((err_raw > -ERR_SMALL) && (err_raw < ERR_SMALL))
        begin
            err_dz = '0;
        end
    end

    assign eff_diff = effort_reg - PCT_HUNDRED;
    assign eff_x9   = {eff_diff, 3'b000} + 27'(eff_diff);
    assign entry_a  = table_entry(volt_lo_reg, volt_hi_reg, 4'(idx_reg));
    assign entry_b  = table_entry(volt_lo_reg, volt_hi_reg, 4'(idx_reg + 1'b1));
    assign entry_s  = table_entry(volt_lo_reg, volt_hi_reg, 4'(SEGS));

    always_comb
    begin
        case (state_reg)
            ST_MI:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed(MUL_W'(integ_gain_reg));
            end
            ST_IACC:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed(MUL_W'(prop_gain_reg));
            end
            ST_BR:
            begin
                if (effort_reg > PCT_HUNDRED)
                begin
                    mul_a = $signed(eff_x9);
                    mul_b = $signed(RECIP_TEN);
                end
                else
                begin
                    mul_a = $signed(MUL_W'(effort_reg));
                    mul_b = $signed(MUL_W'(SEGS));
                end
            end
            ST_MA:
            begin
                mul_a = $signed(MUL_W'(entry_a));
                mul_b = $signed(MUL_W'(SPAN - rem_reg));
            end
            ST_MB:
            begin
                mul_a = $signed(MUL_W'(entry_b));
                mul_b = $signed(MUL_W'(rem_reg));
            end
            ST_Q:
            begin
                mul_a = $signed(MUL_W'(v_reg));
                mul_b = $signed(RECIP_HUNDRED);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign isum    = (state_reg == ST_IACC) ? $signed({12'd0, integ_acc_reg}) + prod_reg[35:0]
                                            : $signed({12'd0, integ_acc_reg}) + prod_reg[35:0];
    assign led_sum = 25'(PCT_TEN) + 25'(prod_reg[52:29]);
    assign vsum    = 35'(acc_reg) + 35'(prod_reg[33:0]);
    assign led_x10 = {1'b0, led_level_reg, 3'b000} + {3'b000, led_level_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (smp_valid) state_next = ST_ERR;
            ST_ERR:  state_next = auto_mode_reg ? ST_MI : ST_DONE;
            ST_MI:   state_next = ST_IACC;
            ST_IACC: state_next = ST_EFF;
            ST_EFF:  state_next = ST_BR;
            ST_BR:   state_next = (effort_reg > PCT_HUNDRED) ? ST_LED : ST_POS;
            ST_LED:  state_next = ST_DONE;
            ST_POS:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (rem_reg < SPAN)
                begin
                    state_next = (idx_reg == IDX_W'(SEGS)) ? ST_DONE : ST_MA;
                end
            end
            ST_MA:   state_next = ST_MB;
            ST_MB:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_Q;
            ST_Q:    state_next = ST_VOLT;
            ST_VOLT: state_next = ST_DONE;
            ST_DONE: if (!res_valid || res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            integ_acc_reg    <= '0;
            led_level_reg    <= '0;
            led_was_lit_reg  <= 1'b0;
            switch_time_reg  <= '0;
            held_voltage_reg <= '0;
            res_valid        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && (!res_valid || res_ready))
            begin
                res_valid <= 1'b1;
            end
            else if (res_valid && res_ready)
            begin
                res_valid <= 1'b0;
            end
            case (state_reg)
                ST_ERR:
                begin
                    if (auto_mode_reg)
                    begin
                        switch_time_reg <= sw_new;
                        led_was_lit_reg <= lit;
                    end
                end
                ST_IACC:
                begin
                    if (isum < 0)
                    begin
                        integ_acc_reg <= '0;
                    end
                    else if (isum > $signed({12'd0, PCT_MAX}))
                    begin
                        integ_acc_reg <= PCT_MAX;
                    end
                    else
                    begin
                        integ_acc_reg <= isum[23:0];
                    end
                end
                ST_LED:
                begin
                    held_voltage_reg <= VOLT_FULL;
                    led_level_reg    <= (led_sum > 25'(PCT_HUNDRED)) ? PCT_HUNDRED[22:0]
                                                                     : led_sum[22:0];
                end
                ST_DIV:
                begin
                    if ((rem_reg >= SPAN) == 1'b0 && idx_reg == IDX_W'(SEGS))
                    begin
                        held_voltage_reg <= entry_s;
                        led_level_reg    <= '0;
                    end
                end
                ST_VOLT:
                begin
                    held_voltage_reg <= prod_reg[33:24];
                    led_level_reg    <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_valid && smp_ready)
        begin
            smp_reg <= smp_data;
        end
        case (state_reg)
            ST_ERR:
            begin
                err_reg  <= err_dz;
                lock_reg <= lock_new;
            end
            ST_EFF:
            begin
                if (isum < 0)
                begin
                    effort_reg <= '0;
                end
                else if (isum > $signed({12'd0, PCT_MAX}))
                begin
                    effort_reg <= PCT_MAX;
                end
                else
                begin
                    effort_reg <= isum[23:0];
                end
            end
            ST_POS:
            begin
                rem_reg <= prod_reg[POS_W-1:0];
                idx_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_reg >= SPAN)
                begin
                    rem_reg <= rem_reg - SPAN;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_MB:   acc_reg <= prod_reg[33:0];
            ST_SUM:  v_reg   <= vsum[32:16];
            ST_DONE:
            begin
                if (!res_valid || res_ready)
                begin
                    res_data.foil_voltage <= held_voltage_reg;
                    res_data.led_compare  <= led_x10[25:16];
                    res_data.lockout      <= lock_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

/* src/srpilux_checker.sv */
// Port-level checker for the split-range light controller and its bind to the top level.
module srpilux_checker
    import srpilux_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    smp_valid,
    input logic    smp_ready,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data,
    input logic    pready
);

    // A result beat that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat dropped or changed while stalled");

    // A lit LED only ever comes with the foil at full voltage.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.led_compare != 10'd0) |-> res_data.foil_voltage == VOLT_FULL)
        else $error("LED lit without full foil voltage");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.led_compare <= 10'd1000)
        else $error("LED compare value out of range");

    // The block is busy in the cycle after it takes a sample beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !smp_ready)
        else $error("sample taken while previous item still in work");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port stalled");

endmodule

bind split_range_pi_lux_controller srpilux_checker u_srpilux_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .pready    (pready)
);

/* tb/sv/tb.sv */
// Testbench for the split-range PI light controller with a built-in predictor.
`timescale 1ns / 1ps

module tb;
    import srpilux_pkg::*;

    localparam longint Q16_ONE         = 65536;
    localparam longint EFFORT_CEIL     = 200 * 65536;
    localparam longint EFFORT_MID      = 100 * 65536;
    localparam longint HANDOVER_LEVEL  = 95 * 65536;
    localparam longint DIM_LED_LEVEL   = 25 * 65536;
    localparam longint LED_FLOOR       = 10 * 65536;
    localparam longint DEAD_WIDE       = 150;
    localparam longint DEAD_NARROW     = 5;
    localparam int     SEGMENTS        = 10;
    localparam logic [9:0] FOIL_FULL_SCALE = 10'd1000;
    localparam int     CYCLE_LIMIT     = 600000;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     REPORT_LIMIT    = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              smp_valid = 1'b0;
    logic              smp_ready;
    sample_t           smp_data = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    result_t           res_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Register copies held by the predictor.
    logic        cfg_auto = 1'b1;
    logic [15:0] cfg_target = 16'd500;
    logic [15:0] cfg_prop = 16'd3277;
    logic [15:0] cfg_integ = 16'd328;
    logic [31:0] cfg_dwell = 32'd10000;
    logic [59:0] cfg_volt_lo = '0;
    logic [49:0] cfg_volt_hi = '0;

    // Controller state held by the predictor.
    longint      integ_level = 0;
    longint      led_level = 0;
    logic        led_lit_prev = 1'b0;
    logic [31:0] switch_tick = '0;
    logic [9:0]  held_volt = '0;

    sample_t     sample_backlog[$];
    result_t     expected_drive[$];
    logic        smp_taken = 1'b0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          items_issued = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [31:0] clock_tick = '0;
    logic [109:0] ramp_table = '0;

    split_range_pi_lux_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_to(input longint v, input longint hi);
        if (v > hi)
            return hi;
        if (v < 0)
            return 0;
        return v;
    endfunction

    function automatic longint volt_entry(input longint k);
        logic [109:0] vt;
        vt = {cfg_volt_hi, cfg_volt_lo};
        return longint'(vt[k * 10 +: 10]);
    endfunction

    function automatic result_t step_controller(input sample_t s);
        longint      err;
        longint      effort;
        longint      pos;
        longint      seg;
        longint      frac;
        logic        lit;
        logic        lock;
        logic [31:0] elapsed;
        result_t     r;
        err = 0;
        if (cfg_auto)
        begin
            lit = (led_level > 0);
            err = longint'(cfg_target) - longint'(s.lux_sample);
            if (lit != led_lit_prev)
            begin
                switch_tick = s.now_ms;
                led_lit_prev = lit;
            end
        end
        elapsed = s.now_ms - switch_tick;
        lock = (elapsed < cfg_dwell);
        if (cfg_auto)
        begin
            if (integ_level >= HANDOVER_LEVEL || led_level > 0)
            begin
                if (led_level == 0)
                begin
                    if (err > 0 && (err <= DEAD_WIDE || lock))
                        err = 0;
                end
                else if (led_level <= DIM_LED_LEVEL)
                begin
                    if (err < 0 && (err >= -DEAD_WIDE || lock))
                        err = 0;
                end
            end
            else if (err > -DEAD_NARROW && err < DEAD_NARROW)
            begin
                err = 0;
            end
            integ_level = clamp_to(integ_level + err * longint'(cfg_integ), EFFORT_CEIL);
            effort = clamp_to(err * longint'(cfg_prop) + integ_level, EFFORT_CEIL);
            if (effort <= EFFORT_MID)
            begin
                pos = effort * SEGMENTS;
                seg = pos / EFFORT_MID;
                frac = pos % EFFORT_MID;
                if (seg >= SEGMENTS)
                    held_volt = 10'(volt_entry(SEGMENTS));
                else
                    held_volt = 10'((volt_entry(seg) * (EFFORT_MID - frac)
                                     + volt_entry(seg + 1) * frac) / EFFORT_MID);
                led_level = 0;
            end
            else
            begin
                held_volt = FOIL_FULL_SCALE;
                led_level = clamp_to(LED_FLOOR + ((effort - EFFORT_MID) * 9) / 10, EFFORT_MID);
            end
        end
        r.foil_voltage = held_volt;
        r.led_compare = 10'((led_level * 10) / Q16_ONE);
        r.lockout = lock;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $realtime,
                     want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Monitor: checks each result beat and predicts each accepted sample beat.
    always @(posedge clk)
    begin : watch
        result_t want;
        smp_taken <= rst_n && smp_valid && smp_ready;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (expected_drive.size() == 0)
            begin
                note_mismatch("unexpected result beat", -1, longint'(res_data));
            end
            else
            begin
                want = expected_drive.pop_front();
                if (res_data.foil_voltage !== want.foil_voltage)
                    note_mismatch("foil_voltage", longint'(want.foil_voltage),
                                  longint'(res_data.foil_voltage));
                if (res_data.led_compare !== want.led_compare)
                    note_mismatch("led_compare", longint'(want.led_compare),
                                  longint'(res_data.led_compare));
                if (res_data.lockout !== want.lockout)
                    note_mismatch("lockout", longint'(want.lockout),
                                  longint'(res_data.lockout));
            end
        end
        if (rst_n && smp_valid && smp_ready)
            expected_drive.push_back(step_controller(smp_data));
    end

    // Driver: presents sample beats from the backlog and randomises the result-side ready.
    always @(negedge clk)
    begin
        if (!smp_valid || smp_taken)
        begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                smp_valid <= 1'b1;
                smp_data <= sample_backlog.pop_front();
            end
            else
            begin
                smp_valid <= 1'b0;
            end
        end
        res_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_AUTO_MODE:    cfg_auto = val[0];
            REG_TARGET_LEVEL: cfg_target = val[15:0];
            REG_PROP_GAIN:    cfg_prop = val[15:0];
            REG_INTEG_GAIN:   cfg_integ = val[15:0];
            REG_DWELL_MS:     cfg_dwell = val[31:0];
            REG_VOLT_LO:      cfg_volt_lo = val[59:0];
            REG_VOLT_HI:      cfg_volt_hi = val[49:0];
            default:          ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(input logic run_auto, input logic [63:0] target,
                                  input logic [63:0] prop, input logic [63:0] integ,
                                  input logic [63:0] dwell, input logic [63:0] volt_lo,
                                  input logic [63:0] volt_hi);
        reg_write(REG_AUTO_MODE, {63'd0, run_auto});
        reg_write(REG_TARGET_LEVEL, target);
        reg_write(REG_PROP_GAIN, prop);
        reg_write(REG_INTEG_GAIN, integ);
        reg_write(REG_DWELL_MS, dwell);
        reg_write(REG_VOLT_LO, volt_lo);
        reg_write(REG_VOLT_HI, volt_hi);
    endtask

    task automatic apply_random_settings(input logic run_auto);
        logic [63:0] prop;
        logic [63:0] integ;
        logic [63:0] dwell;
        prop = $urandom_range(1) ? 64'($urandom_range(0, 8000))
                                 : 64'($urandom_range(0, 65535));
        integ = $urandom_range(1) ? 64'($urandom_range(0, 2000))
                                  : 64'($urandom_range(0, 65535));
        dwell = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 30000));
        apply_settings(run_auto, 64'($urandom_range(50, 3000)), prop, integ, dwell,
                       {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic add_sample(input logic [15:0] lux, input logic [31:0] now);
        sample_t s;
        s.lux_sample = lux;
        s.now_ms = now;
        sample_backlog.push_back(s);
        items_issued++;
    endtask

    function automatic logic [31:0] next_gap();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return $urandom_range(0, 40);
        if (pick < 9)
            return $urandom_range(0, 30000);
        return $urandom;
    endfunction

    // Mostly steady runs around an offset from the set point, mixed with near misses and noise.
    task automatic add_random_samples(input int n);
        int count;
        int kind;
        int run;
        int bias;
        int lux;
        count = 0;
        while (count < n)
        begin
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                run = $urandom_range(4, 30);
                bias = int'($urandom_range(0, 1000)) - 400;
                for (int k = 0; k < run && count < n; k++)
                begin
                    lux = int'(cfg_target) - bias + int'($urandom_range(0, 40)) - 20;
                    if (lux < 0)
                        lux = 0;
                    if (lux > 65535)
                        lux = 65535;
                    clock_tick = clock_tick + next_gap();
                    add_sample(16'(lux), clock_tick);
                    count++;
                end
            end
            else if (kind < 88)
            begin
                lux = int'(cfg_target) + int'($urandom_range(0, 16)) - 8;
                if (lux < 0)
                    lux = 0;
                if (lux > 65535)
                    lux = 65535;
                clock_tick = clock_tick + next_gap();
                add_sample(16'(lux), clock_tick);
                count++;
            end
            else
            begin
                add_sample(16'($urandom), $urandom);
                count++;
            end
        end
    endtask

    task automatic drain();
        while (results_seen != items_issued)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        for (int k = 0; k <= SEGMENTS; k++)
            ramp_table[k * 10 +: 10] = 10'(k * 100);
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apply_settings(1'b1, 500, 20000, 8000, 1000,
                       {4'd0, ramp_table[59:0]}, {14'd0, ramp_table[109:60]});
        add_sample(16'd496, 32'd0);
        add_sample(16'd504, 32'd0);
        add_sample(16'd495, 32'd1);
        add_sample(16'd505, 32'd2);
        add_sample(16'd500, 32'd3);
        add_sample(16'd0, 32'd4);
        add_sample(16'd0, 32'd5);
        add_sample(16'd650, 32'd6);
        add_sample(16'd651, 32'd7);
        add_sample(16'd620, 32'd8);
        add_sample(16'd65535, 32'd2000);
        add_sample(16'd350, 32'd2001);
        add_sample(16'd349, 32'd2002);
        add_sample(16'd420, 32'd2003);
        add_sample(16'd460, 32'd4000);
        add_sample(16'd0, 32'hFFFF_FFF0);
        add_sample(16'd0, 32'hFFFF_FFFF);
        add_sample(16'd640, 32'h0000_0004);
        add_sample(16'd900, 32'h0000_0800);
        add_sample(16'd65535, 32'hFFFF_FFFF);
        add_sample(16'd500, 32'h0000_0000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 77;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 77;
                end
                default:
                begin
                    src_idle_pct = 19;
                    sink_stall_pct = 19;
                end
            endcase
            case (ph)
                0: apply_settings(1'b1, 500, 3277, 328, 10000,
                                  {4'd0, ramp_table[59:0]}, {14'd0, ramp_table[109:60]});
                2: apply_settings(1'b1, 64'hFFFF, 64'hFFFF, 64'hFFFF, 64'hFFFF_FFFF,
                                  {64{1'b1}}, {64{1'b1}});
                3: apply_settings(1'b1, 0, 0, 0, 0, 0, 0);
                4: apply_random_settings(1'b0);
                default: apply_random_settings(1'b1);
            endcase
            add_random_samples(72);
            drain();
        end

        if (mismatch_count == 0 && expected_drive.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
